@@ rtl/tmp_pkg.sv @@
// ---------------------------------------------------------------------------
// tmp_pkg: shared types and constants for the tile mean pixelate block
// Field widths, command kinds, error codes and the command item layout.
// ---------------------------------------------------------------------------
package tmp_pkg;

  localparam int CFG_W   = 11;  // register width
  localparam int PIX_W   = 8;   // one colour channel
  localparam int SUM_W   = 28;  // tile channel sum
  localparam int TIDX_W  = 16;  // tile index field, covers the largest tile count
  localparam int AREA_W  = 2 * CFG_W;
  localparam int ERR_W   = 2;
  localparam int CIDX_W  = 2;

  localparam int MAX_DIM_DEF   = 1024;
  localparam int MAX_TILES_DEF = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RST = CFG_W'(64);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(64);
  localparam logic [CFG_W-1:0] TILE_RST = CFG_W'(8);

  // register indexes
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TILE   = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TILE_SIZE  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NOT_LOADED = 2'd3;

  // input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // command kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] tile;
    logic [CFG_W:0]   across;
  } geo_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ERR_W-1:0]  err;
    logic              first;
    logic              last;
    logic [TIDX_W-1:0] idx;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [CFG_W-1:0]  tw;
    logic [CFG_W-1:0]  th;
  } cmd_t;

  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic              first;
    logic              origin;
    logic              frame_end;
    logic [CFG_W-1:0]  tw;
    logic [CFG_W-1:0]  th;
  } pos_t;

endpackage

@@ rtl/tmp_ram.sv @@
// ---------------------------------------------------------------------------
// tmp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tmp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                          rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/tmp_pos.sv @@
// ---------------------------------------------------------------------------
// tmp_pos: raster position tracker
// Walks pixels in raster order and keeps the tile index, tile corner flags
// and the clipped tile size without any division.
// ---------------------------------------------------------------------------
module tmp_pos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          advance,
  input  tmp_pkg::geo_t geo,
  output tmp_pkg::pos_t pos
);
  import tmp_pkg::*;

  logic [CFG_W-1:0]  col_r, col_nxt, cit_r, cit_nxt, left_r, left_nxt;
  logic [CFG_W-1:0]  row_r, row_nxt, rit_r, rit_nxt, top_r, top_nxt;
  logic [TIDX_W-1:0] tcol_r, tcol_nxt, rbase_r, rbase_nxt;
  logic [CFG_W-1:0]  w_left, h_top;
  logic              col_end, row_end, cit_wrap, rit_wrap;

  assign cit_wrap = (cit_r + CFG_W'(1)) == geo.tile;
  assign rit_wrap = (rit_r + CFG_W'(1)) == geo.tile;
  assign col_end  = ({1'b0, col_r} + 12'd1) >= {1'b0, geo.width};
  assign row_end  = ({1'b0, row_r} + 12'd1) >= {1'b0, geo.height};
  assign w_left   = geo.width - left_r;
  assign h_top    = geo.height - top_r;

  always_comb begin
    col_nxt = col_r; cit_nxt = cit_r; left_nxt = left_r; tcol_nxt = tcol_r;
    row_nxt = row_r; rit_nxt = rit_r; top_nxt = top_r; rbase_nxt = rbase_r;
    if (clear) begin
      col_nxt = '0; cit_nxt = '0; left_nxt = '0; tcol_nxt = '0;
      row_nxt = '0; rit_nxt = '0; top_nxt = '0; rbase_nxt = '0;
    end else if (advance) begin
      if (col_end) begin
        col_nxt = '0; cit_nxt = '0; left_nxt = '0; tcol_nxt = '0;
        if (row_end) begin
          row_nxt = '0; rit_nxt = '0; top_nxt = '0; rbase_nxt = '0;
        end else begin
          row_nxt = row_r + CFG_W'(1);
          if (rit_wrap) begin
            rit_nxt   = '0;
            top_nxt   = top_r + geo.tile;
            rbase_nxt = rbase_r + TIDX_W'(geo.across);
          end else begin
            rit_nxt = rit_r + CFG_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + CFG_W'(1);
        if (cit_wrap) begin
          cit_nxt  = '0;
          left_nxt = left_r + geo.tile;
          tcol_nxt = tcol_r + TIDX_W'(1);
        end else begin
          cit_nxt = cit_r + CFG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; cit_r <= '0; left_r <= '0; tcol_r <= '0;
      row_r <= '0; rit_r <= '0; top_r <= '0; rbase_r <= '0;
    end else begin
      col_r <= col_nxt; cit_r <= cit_nxt; left_r <= left_nxt; tcol_r <= tcol_nxt;
      row_r <= row_nxt; rit_r <= rit_nxt; top_r <= top_nxt; rbase_r <= rbase_nxt;
    end
  end

  assign pos.idx       = rbase_r + tcol_r;
  assign pos.first     = (cit_r == '0) && (rit_r == '0);
  assign pos.origin    = (col_r == '0) && (row_r == '0);
  assign pos.frame_end = col_end && row_end;
  assign pos.tw        = (w_left < geo.tile) ? w_left : geo.tile;
  assign pos.th        = (h_top < geo.tile) ? h_top : geo.tile;
endmodule

@@ rtl/tmp_queue.sv @@
// ---------------------------------------------------------------------------
// tmp_queue: two-entry command queue
// Decouples the classifying front end from the tile store back end.
// ---------------------------------------------------------------------------
module tmp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tmp_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output tmp_pkg::cmd_t dout,
  output logic          empty
);
  import tmp_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ rtl/tmp_front.sv @@
// ---------------------------------------------------------------------------
// tmp_front: configuration, geometry check and item classification
// Holds the registers, checks the geometry after each write and turns each
// accepted item into a command for the back end.
// ---------------------------------------------------------------------------
module tmp_front #(
  parameter int MAX_DIM   = tmp_pkg::MAX_DIM_DEF,
  parameter int MAX_TILES = tmp_pkg::MAX_TILES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tmp_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tmp_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       accept,
  input  logic                       op,
  input  logic [tmp_pkg::PIX_W-1:0]  red,
  input  logic [tmp_pkg::PIX_W-1:0]  green,
  input  logic [tmp_pkg::PIX_W-1:0]  blue,
  output logic                       calc_busy,
  output logic                       push,
  output tmp_pkg::cmd_t              cmd
);
  import tmp_pkg::*;

  localparam int DQ_W = CFG_W + 1;
  localparam int CNT_W = $clog2(DQ_W + 1);

  logic [CFG_W-1:0] w_r, h_r, t_r;
  logic             wr_valid;
  logic             calc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DQ_W-1:0]  nw_r, nh_r;
  logic [CFG_W-1:0] rw_r, rh_r;
  logic [DQ_W-1:0]  shw, shh;
  logic             gew, geh;
  logic             mul_r;
  logic [ERR_W-1:0] err_r;
  logic [CFG_W:0]   across_r;
  logic             bounds_bad;
  logic [CFG_W-1:0] narrow;
  logic             loaded_r;
  geo_t             geo;
  pos_t             lpos, rpos;
  logic             do_load, do_read;

  assign wr_valid = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                               cfg_index == REG_TILE);

  assign narrow = (w_r < h_r) ? w_r : h_r;
  assign bounds_bad = (w_r == '0) || (h_r == '0) ||
                      (32'(w_r) > 32'(MAX_DIM)) || (32'(h_r) > 32'(MAX_DIM)) ||
                      (t_r == '0) || (t_r > narrow);

  // one quotient bit per cycle for both tile counts
  assign shw = {rw_r, nw_r[DQ_W-1]};
  assign shh = {rh_r, nh_r[DQ_W-1]};
  assign gew = shw >= {1'b0, t_r};
  assign geh = shh >= {1'b0, t_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WIDTH_RST; h_r <= HEIGHT_RST; t_r <= TILE_RST;
      calc_r <= 1'b1; mul_r <= 1'b0; cnt_r <= CNT_W'(1);
      err_r <= ERR_NONE; across_r <= '0;
      nw_r <= DQ_W'(WIDTH_RST) + DQ_W'(TILE_RST) - DQ_W'(1);
      nh_r <= DQ_W'(HEIGHT_RST) + DQ_W'(TILE_RST) - DQ_W'(1);
      rw_r <= '0; rh_r <= '0;
    end else if (wr_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  w_r <= cfg_data;
        REG_HEIGHT: h_r <= cfg_data;
        default:    t_r <= cfg_data;
      endcase
      calc_r <= 1'b1; mul_r <= 1'b0; cnt_r <= '0;
      nw_r <= '0; nh_r <= '0; rw_r <= '0; rh_r <= '0;
    end else if (calc_r && !mul_r && cnt_r == '0 && nw_r == '0 && rw_r == '0) begin
      // load the dividends on the cycle after a write
      nw_r  <= DQ_W'(w_r) + DQ_W'(t_r) - DQ_W'(1);
      nh_r  <= DQ_W'(h_r) + DQ_W'(t_r) - DQ_W'(1);
      cnt_r <= CNT_W'(1);
    end else if (calc_r && !mul_r) begin
      nw_r <= {nw_r[DQ_W-2:0], gew};
      nh_r <= {nh_r[DQ_W-2:0], geh};
      rw_r <= gew ? CFG_W'(shw - {1'b0, t_r}) : CFG_W'(shw);
      rh_r <= geh ? CFG_W'(shh - {1'b0, t_r}) : CFG_W'(shh);
      if (cnt_r == CNT_W'(DQ_W)) begin
        mul_r <= 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (calc_r) begin
      across_r <= nw_r;
      if (bounds_bad) begin
        err_r <= ERR_TILE_SIZE;
      end else if (32'(nw_r) * 32'(nh_r) > 32'(MAX_TILES)) begin
        err_r <= ERR_TOO_MANY;
      end else begin
        err_r <= ERR_NONE;
      end
      calc_r <= 1'b0;
      mul_r  <= 1'b0;
    end
  end

  assign calc_busy = calc_r;

  assign geo.width  = w_r;
  assign geo.height = h_r;
  assign geo.tile   = t_r;
  assign geo.across = across_r;

  assign do_load = accept && err_r == ERR_NONE && op == OP_LOAD;
  assign do_read = accept && err_r == ERR_NONE && op == OP_READ && loaded_r;

  tmp_pos u_load_pos (
    .clk, .rst_n, .clear(wr_valid), .advance(do_load), .geo, .pos(lpos)
  );
  tmp_pos u_read_pos (
    .clk, .rst_n, .clear(wr_valid || (do_load && lpos.origin)), .advance(do_read),
    .geo, .pos(rpos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || wr_valid) begin
      loaded_r <= 1'b0;
    end else if (do_load) begin
      loaded_r <= lpos.frame_end ? 1'b1 : (lpos.origin ? 1'b0 : loaded_r);
    end
  end

  assign push = accept;

  always_comb begin
    cmd       = '0;
    cmd.red   = red;
    cmd.green = green;
    cmd.blue  = blue;
    if (err_r != ERR_NONE) begin
      cmd.kind = KIND_ERR;
      cmd.err  = err_r;
    end else if (op == OP_LOAD) begin
      cmd.kind  = KIND_LOAD;
      cmd.idx   = lpos.idx;
      cmd.first = lpos.first;
    end else if (!loaded_r) begin
      cmd.kind = KIND_ERR;
      cmd.err  = ERR_NOT_LOADED;
    end else begin
      cmd.kind = KIND_READ;
      cmd.idx  = rpos.idx;
      cmd.last = rpos.frame_end;
      cmd.tw   = rpos.tw;
      cmd.th   = rpos.th;
    end
  end
endmodule

@@ rtl/tmp_back.sv @@
// ---------------------------------------------------------------------------
// tmp_back: tile sum store and mean divider
// Accumulates loaded pixels into the tile sums and divides them for reads.
// ---------------------------------------------------------------------------
module tmp_back #(
  parameter int MAX_TILES = tmp_pkg::MAX_TILES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      empty,
  input  tmp_pkg::cmd_t             head,
  output logic                      pop,
  output logic                      out_strobe,
  output logic [tmp_pkg::PIX_W-1:0] out_red,
  output logic [tmp_pkg::PIX_W-1:0] out_green,
  output logic [tmp_pkg::PIX_W-1:0] out_blue,
  output logic [tmp_pkg::ERR_W-1:0] out_error_code,
  output logic                      out_last_pixel
);
  import tmp_pkg::*;

  localparam int AW    = MAX_TILES > 1 ? $clog2(MAX_TILES) : 1;
  localparam int NUM_W = SUM_W + 1;
  localparam int RW    = AREA_W + 1;
  localparam int DC_W  = $clog2(NUM_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          st_r;
  cmd_t                cur_r;
  logic [AREA_W-1:0]   area_r;
  logic [3*SUM_W-1:0]  rdata, wdata;
  logic                we;
  logic [SUM_W-1:0]    sum [3];
  logic [PIX_W-1:0]    pix [3];
  logic [NUM_W-1:0]    num_r [3];
  logic [AREA_W-1:0]   rem_r [3];
  logic [RW-1:0]       sh [3];
  logic                ge [3];
  logic [DC_W-1:0]     cnt_r;
  logic                strobe_r, last_r;
  logic [ERR_W-1:0]    err_r;
  logic [PIX_W-1:0]    res_r [3];

  assign pop = (st_r == S_IDLE) && !empty;

  tmp_ram #(.W(3 * SUM_W), .DEPTH(MAX_TILES)) u_sums (
    .clk,
    .we,
    .waddr(cur_r.idx[AW-1:0]),
    .wdata,
    .raddr(head.idx[AW-1:0]),
    .rdata
  );

  assign pix[0] = cur_r.red;
  assign pix[1] = cur_r.green;
  assign pix[2] = cur_r.blue;
  assign we = st_r == S_LD;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign sum[c] = rdata[c*SUM_W +: SUM_W];
    assign wdata[c*SUM_W +: SUM_W] = cur_r.first ? SUM_W'(pix[c]) : sum[c] + SUM_W'(pix[c]);
    assign sh[c] = {rem_r[c], num_r[c][NUM_W-1]};
    assign ge[c] = sh[c] >= {1'b0, area_r};
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        cur_r  <= head;
        area_r <= AREA_W'(head.tw) * AREA_W'(head.th);
      end
      S_RD: begin
        for (int c = 0; c < 3; c++) begin
          num_r[c] <= NUM_W'(sum[c]) + NUM_W'(area_r >> 1);
          rem_r[c] <= '0;
        end
      end
      S_DIV: begin
        for (int c = 0; c < 3; c++) begin
          num_r[c] <= {num_r[c][NUM_W-2:0], ge[c]};
          rem_r[c] <= ge[c] ? AREA_W'(sh[c] - {1'b0, area_r}) : AREA_W'(sh[c]);
        end
      end
      default: begin
      end
    endcase
    // saturate each mean to one channel
    if (st_r == S_OUT) begin
      for (int c = 0; c < 3; c++) begin
        if (cur_r.kind == KIND_ERR) begin
          res_r[c] <= '0;
        end else begin
          res_r[c] <= (|num_r[c][NUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : num_r[c][PIX_W-1:0];
        end
      end
      err_r  <= (cur_r.kind == KIND_ERR) ? cur_r.err : ERR_NONE;
      last_r <= (cur_r.kind == KIND_READ) && cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (!empty) begin
            if (head.kind == KIND_LOAD) begin
              st_r <= S_LD;
            end else if (head.kind == KIND_READ) begin
              st_r <= S_RD;
            end else begin
              st_r <= S_OUT;
            end
          end
        end
        S_LD: st_r <= S_IDLE;
        S_RD: begin
          cnt_r <= '0;
          st_r  <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + DC_W'(1);
          if (cnt_r == DC_W'(NUM_W - 1)) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          strobe_r <= 1'b1;
          st_r     <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe     = strobe_r;
  assign out_red        = res_r[0];
  assign out_green      = res_r[1];
  assign out_blue       = res_r[2];
  assign out_error_code = err_r;
  assign out_last_pixel = last_r;
endmodule

@@ rtl/tile_mean_pixelate.sv @@
// ---------------------------------------------------------------------------
// tile_mean_pixelate: mosaic filter with clipped tile means
// Loads accumulate RGB sums per square tile; reads return each pixel's tile
// mean, rounded to nearest, in raster order.
// ---------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | start & !busy       | in_op, in_red, in_green, in_blue
//  result   | out_strobe (1 cyc)  | out_red/green/blue, out_error_code,
//           |                     | out_last_pixel
//  config   | cfg_we              | cfg_index, cfg_data
//
// Timing: a load item holds the back end while its sum is read as it leaves
// the queue and is then added and written back; a read item holds it through
// the bit-serial mean divider (one quotient bit per cycle over a 29-bit
// dividend) before its result shows; an error item holds it only to put out
// its code. A two-entry queue lets the front take items while the back end
// works. Busy stays high after every register write and after reset while
// the tile counts are worked out.
// Reset is synchronous and clears control state only; the tile sums are never
// cleared. The receiver cannot stall, so each result shows for exactly one
// cycle.
module tile_mean_pixelate #(
  parameter int MAX_DIM   = tmp_pkg::MAX_DIM_DEF,
  parameter int MAX_TILES = tmp_pkg::MAX_TILES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [tmp_pkg::PIX_W-1:0]  in_red,
  input  logic [tmp_pkg::PIX_W-1:0]  in_green,
  input  logic [tmp_pkg::PIX_W-1:0]  in_blue,
  output logic                       out_strobe,
  output logic [tmp_pkg::PIX_W-1:0]  out_red,
  output logic [tmp_pkg::PIX_W-1:0]  out_green,
  output logic [tmp_pkg::PIX_W-1:0]  out_blue,
  output logic [tmp_pkg::ERR_W-1:0]  out_error_code,
  output logic                       out_last_pixel,
  input  logic                       cfg_we,
  input  logic [tmp_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tmp_pkg::CFG_W-1:0]  cfg_data
);
  import tmp_pkg::*;

  logic calc_busy, push, full, pop, empty;
  cmd_t cmd, head;

  // hold off new items while the geometry is checked or the queue is full
  assign busy = calc_busy || full;

  tmp_front #(.MAX_DIM(MAX_DIM), .MAX_TILES(MAX_TILES)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .accept(start && !busy), .op(in_op),
    .red(in_red), .green(in_green), .blue(in_blue),
    .calc_busy, .push, .cmd
  );

  tmp_queue u_queue (
    .clk, .rst_n, .push, .din(cmd), .full, .pop, .dout(head), .empty
  );

  tmp_back #(.MAX_TILES(MAX_TILES)) u_back (
    .clk, .rst_n, .empty, .head, .pop,
    .out_strobe, .out_red, .out_green, .out_blue, .out_error_code, .out_last_pixel
  );
endmodule
